/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/gfw_pkg.sv */
// shared constants, types and helpers of the depth-first walk block
`timescale 1ns / 1ps
package gfw_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;
  localparam int VERT_W       = 4;
  localparam int VERT_N       = 2 ** VERT_W;
  localparam int EDGE_AW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PTR_W        = $clog2(MAX_EDGES + 1);
  localparam logic [PTR_W-1:0] NIL_EDGE = PTR_W'(MAX_EDGES);

  typedef logic [VERT_W-1:0]  vertex_t;
  typedef logic [PTR_W-1:0]   edge_ptr_t;
  typedef logic [EDGE_AW-1:0] edge_addr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_START,
    S_FETCH,
    S_CHECK,
    S_EMIT,
    S_FINAL,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic link;
    logic start;
    logic pop;
    logic fetch;
    logic check;
    logic emit;
    logic emit_last;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic start_ok;
    logic cursor_nil;
    logic stack_empty;
    logic found;
    logic out_free;
  } status_t;

  function automatic logic in_range(vertex_t v);
    return int'(v) < MAX_VERTICES;
  endfunction
endpackage

/* hw/rtl/gfw_ifs.sv */
// valid/ready channel interfaces for edges in and visited vertices out
`timescale 1ns / 1ps
interface gfw_edge_if;
  logic              valid;
  logic              ready;
  gfw_pkg::vertex_t  from_vertex;
  gfw_pkg::vertex_t  to_vertex;
  logic              last_edge;

  modport source (output valid, output from_vertex, output to_vertex, output last_edge,
                  input ready);
  modport sink (input valid, input from_vertex, input to_vertex, input last_edge,
                output ready);
endinterface

interface gfw_vert_if;
  logic              valid;
  logic              ready;
  gfw_pkg::vertex_t  visited_vertex;
  logic              last_vertex;
  logic              edges_dropped;

  modport source (output valid, output visited_vertex, output last_vertex,
                  output edges_dropped, input ready);
  modport sink (input valid, input visited_vertex, input last_vertex,
                input edges_dropped, output ready);
endinterface

/* hw/rtl/gfw_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module gfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/gfw_ctrl.sv */
// controller state machine: edge loading, walk sequencing and cleanup
`timescale 1ns / 1ps
module gfw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gfw_pkg::status_t  st,
  output logic              in_ready,
  output gfw_pkg::cmd_t     cmd
);
  gfw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gfw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = gfw_pkg::S_LINK;
        end
      end
      gfw_pkg::S_LINK: begin
        cmd.link   = 1'b1;
        state_next = st.last ? gfw_pkg::S_START : gfw_pkg::S_IDLE;
      end
      gfw_pkg::S_START: begin
        if (st.start_ok) begin
          cmd.start  = 1'b1;
          state_next = gfw_pkg::S_FETCH;
        end else begin
          state_next = gfw_pkg::S_CLEAR;
        end
      end
      gfw_pkg::S_FETCH: begin
        // list of the top frame exhausted: pop it, or finish on the last frame
        if (st.cursor_nil) begin
          if (st.stack_empty) begin
            state_next = gfw_pkg::S_FINAL;
          end else begin
            cmd.pop = 1'b1;
          end
        end else begin
          cmd.fetch  = 1'b1;
          state_next = gfw_pkg::S_CHECK;
        end
      end
      gfw_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.found ? gfw_pkg::S_EMIT : gfw_pkg::S_FETCH;
      end
      gfw_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gfw_pkg::S_FETCH;
        end
      end
      gfw_pkg::S_FINAL: begin
        if (st.out_free) begin
          cmd.emit_last = 1'b1;
          state_next    = gfw_pkg::S_CLEAR;
        end
      end
      gfw_pkg::S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = gfw_pkg::S_IDLE;
      end
      default: begin
        state_next = gfw_pkg::S_IDLE;
      end
    endcase
  end
endmodule

/* hw/rtl/gfw_dp.sv */
// datapath: adjacency store, visited marks, walk stack and output register
`timescale 1ns / 1ps
module gfw_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  gfw_pkg::vertex_t  cfg_wr_data,
  input  gfw_pkg::cmd_t     cmd,
  output gfw_pkg::status_t  st,
  input  gfw_pkg::vertex_t  from_vertex,
  input  gfw_pkg::vertex_t  to_vertex,
  input  logic              last_edge,
  input  logic              out_ready,
  output logic              out_valid,
  output gfw_pkg::vertex_t  visited_vertex,
  output logic              last_vertex,
  output logic              edges_dropped
);
  gfw_pkg::vertex_t    start_vertex;
  logic [gfw_pkg::VERT_N-1:0] used;
  logic [gfw_pkg::VERT_N-1:0] visited;
  gfw_pkg::edge_addr_t list_first [gfw_pkg::VERT_N];
  gfw_pkg::edge_addr_t list_tail  [gfw_pkg::VERT_N];
  gfw_pkg::edge_ptr_t  walk_stack [gfw_pkg::VERT_N];
  gfw_pkg::edge_ptr_t  count;
  logic                overflow;
  logic                link_pend;
  gfw_pkg::edge_addr_t link_addr;
  gfw_pkg::edge_ptr_t  link_val;
  logic                last_r;
  gfw_pkg::edge_ptr_t  cursor;
  gfw_pkg::vertex_t    depth;
  gfw_pkg::vertex_t    pending;
  gfw_pkg::vertex_t    found_v;

  gfw_pkg::vertex_t    tgt_rdata;
  gfw_pkg::edge_ptr_t  nxt_rdata;
  logic                edge_ok;
  logic                found;
  gfw_pkg::vertex_t    first_addr;
  gfw_pkg::edge_ptr_t  first_ptr;
  logic                nxt_we;
  gfw_pkg::edge_addr_t nxt_waddr;
  gfw_pkg::edge_ptr_t  nxt_wdata;

  assign edge_ok = gfw_pkg::in_range(from_vertex) && gfw_pkg::in_range(to_vertex) &&
                   (count < gfw_pkg::NIL_EDGE);
  assign found   = gfw_pkg::in_range(tgt_rdata) && !visited[tgt_rdata];

  // head of a vertex's list, for the start vertex or a newly found one
  assign first_addr = cmd.start ? start_vertex : tgt_rdata;
  assign first_ptr  = used[first_addr] ? gfw_pkg::PTR_W'(list_first[first_addr])
                                       : gfw_pkg::NIL_EDGE;

  // new edge ends its list; the second write links the old tail to it
  assign nxt_we    = (cmd.accept && edge_ok) || (cmd.link && link_pend);
  assign nxt_waddr = cmd.accept ? count[gfw_pkg::EDGE_AW-1:0] : link_addr;
  assign nxt_wdata = cmd.accept ? gfw_pkg::NIL_EDGE : link_val;

  gfw_ram #(.WIDTH(gfw_pkg::VERT_W), .DEPTH(gfw_pkg::MAX_EDGES)) u_target_ram (
    .clk   (clk),
    .we    (cmd.accept && edge_ok),
    .waddr (count[gfw_pkg::EDGE_AW-1:0]),
    .wdata (to_vertex),
    .re    (cmd.fetch),
    .raddr (cursor[gfw_pkg::EDGE_AW-1:0]),
    .rdata (tgt_rdata)
  );

  gfw_ram #(.WIDTH(gfw_pkg::PTR_W), .DEPTH(gfw_pkg::MAX_EDGES)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (cmd.fetch),
    .raddr (cursor[gfw_pkg::EDGE_AW-1:0]),
    .rdata (nxt_rdata)
  );

  always_comb begin
    st             = '0;
    st.last        = last_r;
    st.start_ok    = gfw_pkg::in_range(start_vertex);
    st.cursor_nil  = (cursor == gfw_pkg::NIL_EDGE);
    st.stack_empty = (depth == '0);
    st.found       = found;
    st.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vertex <= gfw_pkg::VERT_W'(1);
      used         <= '0;
      visited      <= '0;
      count        <= '0;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_vertex <= cfg_wr_data;
      end
      if (cmd.accept) begin
        last_r    <= last_edge;
        link_pend <= 1'b0;
        if (edge_ok) begin
          list_tail[from_vertex] <= count[gfw_pkg::EDGE_AW-1:0];
          count                  <= count + gfw_pkg::PTR_W'(1);
          if (used[from_vertex]) begin
            link_pend <= 1'b1;
            link_addr <= list_tail[from_vertex];
            link_val  <= count;
          end else begin
            used[from_vertex]       <= 1'b1;
            list_first[from_vertex] <= count[gfw_pkg::EDGE_AW-1:0];
          end
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.start) begin
        visited[start_vertex] <= 1'b1;
        pending               <= start_vertex;
        cursor                <= first_ptr;
        depth                 <= '0;
      end
      if (cmd.pop) begin
        cursor <= walk_stack[depth - gfw_pkg::VERT_W'(1)];
        depth  <= depth - gfw_pkg::VERT_W'(1);
      end
      if (cmd.check) begin
        cursor <= nxt_rdata;
        if (found) begin
          // save the advanced cursor and descend into the new vertex
          visited[tgt_rdata] <= 1'b1;
          found_v            <= tgt_rdata;
          walk_stack[depth]  <= nxt_rdata;
          depth              <= depth + gfw_pkg::VERT_W'(1);
          cursor             <= first_ptr;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // a visited vertex is held back until it is known whether it is the last
      if (cmd.emit || cmd.emit_last) begin
        out_valid      <= 1'b1;
        visited_vertex <= pending;
        last_vertex    <= cmd.emit_last;
        edges_dropped  <= overflow;
        if (cmd.emit) begin
          pending <= found_v;
        end
      end
      if (cmd.clear) begin
        used     <= '0;
        visited  <= '0;
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/graph_depth_first_walk.sv */
// top level: depth-first walk over a directed graph loaded edge by edge
//
//   channel    dir  payload                                      item
//   edge_in    in   from_vertex, to_vertex, last_edge            one directed edge
//   vert_out   out  visited_vertex, last_vertex, edges_dropped   one visited vertex
//   cfg_wr_*   in   start_vertex                                 register write
//
// each edge is stored in S_IDLE, then S_LINK does the link write into the
// old tail of its source list (single write port of the next-edge ram)
// the walk does a fetch (ram read) and a check per edge examined, an emit per
// newly found vertex and a pop per popped frame, plus start, final and clear
// a stall on vert_out holds the walk at the next emit; no edge is taken meanwhile
// reset is synchronous and needs no clearing pass; start_vertex resets to 1
`timescale 1ns / 1ps
`include "assert_macros.svh"
module graph_depth_first_walk (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  gfw_pkg::vertex_t  cfg_wr_data,
  gfw_edge_if.sink          edge_in,
  gfw_vert_if.source        vert_out
);
  gfw_pkg::cmd_t    cmd;
  gfw_pkg::status_t st;
  logic             in_ready;

  assign edge_in.ready = in_ready;

  gfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edge_in.valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gfw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .st             (st),
    .from_vertex    (edge_in.from_vertex),
    .to_vertex      (edge_in.to_vertex),
    .last_edge      (edge_in.last_edge),
    .out_ready      (vert_out.ready),
    .out_valid      (vert_out.valid),
    .visited_vertex (vert_out.visited_vertex),
    .last_vertex    (vert_out.last_vertex),
    .edges_dropped  (vert_out.edges_dropped)
  );

  // an accepted edge is always followed by its link cycle
  `ASSERT_NEXT(a_link_after_accept, edge_in.valid && edge_in.ready, !edge_in.ready)
  // the controller only emits into a free output register
  `ASSERT_IMPL(a_emit_has_room, cmd.emit || cmd.emit_last, !vert_out.valid || vert_out.ready)
  // the closing emit shows up as a marked final vertex
  `ASSERT_NEXT(a_final_marked, cmd.emit_last, vert_out.valid && vert_out.last_vertex)
  // no edge is taken while the walk runs
  `ASSERT_IMPL(a_no_accept_in_walk, cmd.check || cmd.emit || cmd.pop, !edge_in.ready)
endmodule

/* tb/graph_depth_first_walk_tb.sv */
// self-checking testbench for the depth-first walk block: table-driven and random graphs
`timescale 1ns / 1ps
module graph_depth_first_walk_tb;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int RAND_ITEMS    = 300;
  localparam int CALM_ITEMS    = 250;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum logic [1:0] {ROW_EDGE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    gfw_pkg::vertex_t  a;      // from vertex, or the new start vertex
    gfw_pkg::vertex_t  b;
    logic              last;
    logic              typed;  // single result given below
    gfw_pkg::vertex_t  ev;
    logic              el;
    logic              ed;
  } stim_row_t;

  typedef struct packed {
    gfw_pkg::vertex_t v;
    logic             last;
    logic             dropped;
  } visit_t;

  localparam int N_ROWS = 20;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_EDGE, 4'd0,  4'd0,  1'b1, 1'b1, 4'd1,  1'b1, 1'b0},
    '{ROW_CFG,  4'd15, 4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd15, 4'd15, 1'b1, 1'b1, 4'd15, 1'b1, 1'b0},
    '{ROW_CFG,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd0,  4'd1,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd0,  4'd2,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd1,  4'd3,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd3,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd2,  4'd15, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd15, 4'd14, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd15, 4'd0,  1'b1, 1'b1, 4'd0,  1'b1, 1'b0},
    '{ROW_CFG,  4'd2,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd2,  4'd5,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd5,  4'd2,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd2,  4'd5,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_CFG,  4'd7,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd7,  4'd15, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd7,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd0,  4'd7,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{ROW_EDGE, 4'd15, 4'd0,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  gfw_pkg::vertex_t cfg_wr_data;

  gfw_edge_if edge_bus ();
  gfw_vert_if vert_bus ();

  graph_depth_first_walk u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .edge_in    (edge_bus),
    .vert_out   (vert_bus)
  );

  // predicted copy of the graph store
  gfw_pkg::vertex_t   g_target [gfw_pkg::MAX_EDGES];
  gfw_pkg::edge_ptr_t g_next   [gfw_pkg::MAX_EDGES];
  gfw_pkg::edge_ptr_t g_head   [gfw_pkg::MAX_VERTICES];
  gfw_pkg::edge_ptr_t g_tail   [gfw_pkg::MAX_VERTICES];
  int                 g_count;
  logic               g_dropped;
  gfw_pkg::vertex_t   g_start;

  visit_t expected_visits [$];
  visit_t walk_order [$];

  int   errors;
  int   cycles;
  int   rand_items;
  logic no_idle;
  logic long_hold_req;

  function automatic void clear_graph();
    for (int v = 0; v < gfw_pkg::MAX_VERTICES; v++) begin
      g_head[v] = gfw_pkg::NIL_EDGE;
      g_tail[v] = gfw_pkg::NIL_EDGE;
    end
    g_count   = 0;
    g_dropped = 1'b0;
  endfunction

  function automatic void store_edge(gfw_pkg::vertex_t f, gfw_pkg::vertex_t t);
    if (int'(f) >= gfw_pkg::MAX_VERTICES || int'(t) >= gfw_pkg::MAX_VERTICES ||
        g_count >= gfw_pkg::MAX_EDGES) begin
      g_dropped = 1'b1;
      return;
    end
    g_target[g_count] = t;
    g_next[g_count]   = gfw_pkg::NIL_EDGE;
    if (int'(g_tail[f]) >= gfw_pkg::MAX_EDGES) g_head[f] = gfw_pkg::edge_ptr_t'(g_count);
    else g_next[g_tail[f]] = gfw_pkg::edge_ptr_t'(g_count);
    g_tail[f] = gfw_pkg::edge_ptr_t'(g_count);
    g_count++;
  endfunction

  // preorder walk with an explicit frame stack, neighbors in insertion order
  function automatic void predict_walk();
    logic [gfw_pkg::MAX_VERTICES-1:0] seen;
    gfw_pkg::edge_ptr_t st_c [gfw_pkg::MAX_VERTICES];
    int                 sp;
    gfw_pkg::edge_ptr_t e;
    gfw_pkg::vertex_t   t;
    gfw_pkg::vertex_t   nxt;
    logic               found;
    walk_order.delete();
    if (int'(g_start) >= gfw_pkg::MAX_VERTICES) return;
    seen = '0;
    seen[g_start] = 1'b1;
    walk_order.push_back('{g_start, 1'b0, g_dropped});
    st_c[0] = g_head[g_start];
    sp = 1;
    while (sp > 0) begin
      e = st_c[sp-1];
      found = 1'b0;
      nxt = '0;
      while (int'(e) < gfw_pkg::MAX_EDGES && !found) begin
        t = g_target[e];
        e = g_next[e];
        if (int'(t) < gfw_pkg::MAX_VERTICES && !seen[t]) begin
          found = 1'b1;
          nxt = t;
        end
      end
      st_c[sp-1] = e;
      if (!found) begin
        sp--;
      end else begin
        seen[nxt] = 1'b1;
        if (walk_order.size() < 16) walk_order.push_back('{nxt, 1'b0, g_dropped});
        if (sp < gfw_pkg::MAX_VERTICES) begin
          st_c[sp] = g_head[nxt];
          sp++;
        end
      end
    end
    if (walk_order.size() > 0) walk_order[walk_order.size()-1].last = 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime, expected_visits.size());
      $display("[graph_depth_first_walk] ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    visit_t exp_v;
    if (!rst && vert_bus.valid && vert_bus.ready) begin
      if (expected_visits.size() == 0) begin
        $display("%0t unexpected vertex %0d last=%0d dropped=%0d", $realtime,
                 vert_bus.visited_vertex, vert_bus.last_vertex, vert_bus.edges_dropped);
        errors++;
      end else begin
        exp_v = expected_visits.pop_front();
        if (vert_bus.visited_vertex !== exp_v.v || vert_bus.last_vertex !== exp_v.last ||
            vert_bus.edges_dropped !== exp_v.dropped) begin
          $display("%0t mismatch: expected v=%0d last=%0d dropped=%0d,", $realtime,
                   exp_v.v, exp_v.last, exp_v.dropped);
          $display("    got v=%0d last=%0d dropped=%0d", vert_bus.visited_vertex,
                   vert_bus.last_vertex, vert_bus.edges_dropped);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    int n;
    vert_bus.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req && expected_visits.size() > 0) begin
        long_hold_req = 1'b0;
        n = 0;
        while (n < LONG_HOLD) begin
          @(negedge clk);
          vert_bus.ready <= 1'b0;
          n++;
        end
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          vert_bus.ready <= 1'b0;
        end
      end else begin
        @(negedge clk);
        vert_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_edge(gfw_pkg::vertex_t f, gfw_pkg::vertex_t t, logic last, logic typed,
                           visit_t typed_v);
    @(negedge clk);
    edge_bus.valid       <= 1'b1;
    edge_bus.from_vertex <= f;
    edge_bus.to_vertex   <= t;
    edge_bus.last_edge   <= last;
    do @(posedge clk); while (!edge_bus.ready);
    store_edge(f, t);
    if (last) begin
      predict_walk();
      if (typed) expected_visits.push_back(typed_v);
      else foreach (walk_order[i]) expected_visits.push_back(walk_order[i]);
      clear_graph();
    end
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        edge_bus.valid <= 1'b0;
      end
    end
  endtask

  // register writes only once the block has gone quiet
  task automatic write_start(gfw_pkg::vertex_t v);
    @(negedge clk);
    edge_bus.valid <= 1'b0;
    while (expected_visits.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    g_start = v;
  endtask

  initial begin
    stim_row_t        row;
    int               n_edges;
    int               vmax;
    int               pick;
    logic             chain;
    gfw_pkg::vertex_t cur;
    gfw_pkg::vertex_t f;
    gfw_pkg::vertex_t t;
    int               g;
    errors        = 0;
    cycles        = 0;
    rand_items    = 0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    g_start       = 4'd1;
    clear_graph();
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    edge_bus.valid       = 1'b0;
    edge_bus.from_vertex = '0;
    edge_bus.to_vertex   = '0;
    edge_bus.last_edge   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) write_start(row.a);
      else send_edge(row.a, row.b, row.last, row.typed, '{row.ev, row.el, row.ed});
    end

    long_hold_req = 1'b1;
    g = 0;
    while (rand_items < RAND_ITEMS) begin
      if (g > 1 && !no_idle && $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) write_start(4'd0);
        else if (pick == 1) write_start(4'd15);
        else write_start(gfw_pkg::vertex_t'($urandom_range(0, 15)));
      end
      // the second graph always overruns the edge store
      pick = $urandom_range(0, 19);
      if (g == 1 || pick == 0) begin
        n_edges = $urandom_range(gfw_pkg::MAX_EDGES + 1, gfw_pkg::MAX_EDGES + 6);
      end else if (pick < 4) n_edges = $urandom_range(16, 40);
      else n_edges = $urandom_range(1, 10);
      vmax  = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(1, 15);
      chain = ($urandom_range(0, 1) == 1);
      cur   = g_start;
      for (int k = 0; k < n_edges; k++) begin
        if (chain && $urandom_range(0, 4) != 0) f = cur;
        else f = gfw_pkg::vertex_t'($urandom_range(0, vmax));
        t = gfw_pkg::vertex_t'($urandom_range(0, vmax));
        cur = t;
        if (rand_items >= CALM_ITEMS) no_idle = 1'b1;
        send_edge(f, t, (k == n_edges - 1), 1'b0, '0);
        rand_items++;
      end
      g++;
    end

    @(negedge clk);
    edge_bus.valid <= 1'b0;
    while (expected_visits.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[graph_depth_first_walk] OK");
    end else begin
      $display("[graph_depth_first_walk] ERROR");
    end
    $finish;
  end
endmodule
